// ===== hw/rtl/tcce_pkg.sv =====
// tcce_pkg: shared types and constants of the text console cursor engine
// request/response payloads, datapath command and status structs, codes
// no dependencies
package tcce_pkg;

	// request codes
	localparam logic [1:0] REQ_PUT    = 2'd0;
	localparam logic [1:0] REQ_READ   = 2'd1;
	localparam logic [1:0] REQ_CLEAR  = 2'd2;
	localparam logic [1:0] REQ_SETCUR = 2'd3;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FOREGROUND = 2'd1;

	// character codes
	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	localparam logic [15:0] CELL_RESET = 16'h0F20;
	localparam logic [3:0]  BG_RESET   = 4'h0;
	localparam logic [3:0]  FG_RESET   = 4'hF;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] char_code;
		logic [4:0] row;
		logic [6:0] col;
	} req_t;

	typedef struct packed {
		logic [15:0] cell_value;
		logic [6:0]  cursor_col;
		logic [4:0]  cursor_row;
		logic        scrolled;
	} rsp_t;

	typedef enum logic [2:0] {
		OP_NONE   = 3'd0,
		OP_FILL   = 3'd1,
		OP_ACCEPT = 3'd2,
		OP_STEP   = 3'd3,
		OP_BLANK  = 3'd4,
		OP_CLEAR  = 3'd5,
		OP_SETCUR = 3'd6,
		OP_READ   = 3'd7
	} op_t;

	typedef struct packed {
		op_t  op;
		logic load_rsp;
	} cmd_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic       is_zero;
		logic       scroll;
		logic       tab_more;
		logic       tab_left;
		logic       cells_last;
		logic       blank_last;
		logic       rsp_free;
	} stat_t;

endpackage

// ===== hw/rtl/tcce_datapath.sv =====
// tcce_datapath: screen store, cursor, scroll offset, sweep counter and response register
// executes one op per cycle from the controller and reports status back
// depends on tcce_pkg
module tcce_datapath #(
	parameter int unsigned COLUMNS    = 80,
	parameter int unsigned ROWS       = 25,
	parameter int unsigned TAB_SPACES = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [tcce_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [3:0]                           cfg_wdata,
	input  tcce_pkg::req_t                       req,
	input  tcce_pkg::cmd_t                       cmd,
	output tcce_pkg::stat_t                      stat,
	output logic                                 rsp_valid,
	input  logic                                 rsp_ready,
	output tcce_pkg::rsp_t                       rsp
);
	import tcce_pkg::*;

	localparam int unsigned CW    = $clog2(COLUMNS);
	localparam int unsigned RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int unsigned CELLS = COLUMNS * ROWS;
	localparam int unsigned AW    = $clog2(CELLS);
	localparam int unsigned TW    = $clog2(TAB_SPACES + 1);

	logic [3:0]    bg_q, fg_q;
	logic [1:0]    rq_type_q;
	logic [7:0]    rq_char_q;
	logic [RW-1:0] rq_row_q;
	logic [CW-1:0] rq_col_q;
	logic [CW-1:0] cur_col_q;
	logic [RW-1:0] cur_row_q;
	logic [RW-1:0] top_q;
	logic [AW-1:0] sweep_q;
	logic [TW-1:0] tab_cnt_q;
	logic          scrolled_q;
	logic [15:0]   rdata_q;
	logic          rsp_valid_q;
	rsp_t          rsp_q;

	logic [15:0] mem [CELLS];

	logic          is_tab, is_newline, col_last, row_last, wrap;
	logic          cells_last, blank_last;
	logic [RW-1:0] top_next, in_row_c;
	logic [CW-1:0] in_col_c;
	logic [7:0]    put_char;
	logic [15:0]   blank_cell;
	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [15:0]   mem_wdata;

	// logical row to physical store address, rows rotate by the scroll offset
	function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] lrow,
			input logic [CW-1:0] c, input logic [RW-1:0] top);
		logic [RW:0] sum;
		sum = {1'b0, lrow} + {1'b0, top};
		if (sum >= (RW+1)'(ROWS)) begin
			sum = sum - (RW+1)'(ROWS);
		end
		return AW'(sum) * AW'(COLUMNS) + AW'(c);
	endfunction

	assign is_tab     = (rq_char_q == CH_TAB);
	assign is_newline = (rq_char_q == CH_NEWLINE);
	assign col_last   = (cur_col_q == CW'(COLUMNS - 1));
	assign row_last   = (cur_row_q == RW'(ROWS - 1));
	assign wrap       = is_newline || col_last;
	assign top_next   = (top_q == RW'(ROWS - 1)) ? '0 : top_q + 1'b1;
	assign cells_last = (sweep_q == AW'(CELLS - 1));
	assign blank_last = (sweep_q == AW'(COLUMNS - 1));
	assign put_char   = is_tab ? CH_SPACE : rq_char_q;
	assign blank_cell = {bg_q, fg_q, CH_SPACE};

	// clamp incoming coordinates to the screen
	assign in_row_c = ({2'b00, req.row} > 7'(ROWS - 1)) ? RW'(ROWS - 1) : RW'(req.row);
	assign in_col_c = ({1'b0, req.col} > 8'(COLUMNS - 1)) ? CW'(COLUMNS - 1) : CW'(req.col);

	assign stat.req_type   = rq_type_q;
	assign stat.is_zero    = (rq_char_q == CH_NUL);
	assign stat.scroll     = wrap && row_last;
	assign stat.tab_more   = is_tab && (tab_cnt_q > TW'(1));
	assign stat.tab_left   = is_tab && (tab_cnt_q != '0);
	assign stat.cells_last = cells_last;
	assign stat.blank_last = blank_last;
	assign stat.rsp_free   = !rsp_valid_q || rsp_ready;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = sweep_q;
		mem_wdata = blank_cell;
		case (cmd.op)
			OP_FILL: begin
				mem_we    = 1'b1;
				mem_wdata = CELL_RESET;
			end
			OP_CLEAR: begin
				mem_we = 1'b1;
			end
			OP_STEP: begin
				mem_we    = !is_newline;
				mem_waddr = cell_addr(cur_row_q, cur_col_q, top_q);
				mem_wdata = {bg_q, fg_q, put_char};
			end
			OP_BLANK: begin
				mem_we    = 1'b1;
				mem_waddr = cell_addr(RW'(ROWS - 1), sweep_q[CW-1:0], top_q);
			end
			default: begin
			end
		endcase
	end

	assign mem_raddr = cell_addr(rq_row_q, rq_col_q, top_q);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_READ) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bg_q <= BG_RESET;
			fg_q <= FG_RESET;
		end else if (cfg_we) begin
			if (cfg_index == CFG_BACKGROUND) begin
				bg_q <= cfg_wdata;
			end else if (cfg_index == CFG_FOREGROUND) begin
				fg_q <= cfg_wdata;
			end
		end
	end

	// request fields, payload only
	always_ff @(posedge clk) begin
		if (cmd.op == OP_ACCEPT) begin
			rq_type_q <= req.req_type;
			rq_char_q <= req.char_code;
			rq_row_q  <= in_row_c;
			rq_col_q  <= in_col_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q  <= '0;
			cur_row_q  <= '0;
			top_q      <= '0;
			sweep_q    <= '0;
			tab_cnt_q  <= '0;
			scrolled_q <= 1'b0;
		end else begin
			case (cmd.op)
				OP_FILL: begin
					sweep_q <= cells_last ? '0 : sweep_q + 1'b1;
				end
				OP_ACCEPT: begin
					scrolled_q <= 1'b0;
					tab_cnt_q  <= TW'(TAB_SPACES);
					sweep_q    <= '0;
				end
				OP_STEP: begin
					if (is_tab) begin
						tab_cnt_q <= tab_cnt_q - 1'b1;
					end
					if (wrap && row_last) begin
						// scroll: rotate rows, last row gets blanked next
						top_q      <= top_next;
						cur_col_q  <= '0;
						scrolled_q <= 1'b1;
					end else if (wrap) begin
						cur_col_q <= '0;
						cur_row_q <= cur_row_q + 1'b1;
					end else begin
						cur_col_q <= cur_col_q + 1'b1;
					end
				end
				OP_BLANK: begin
					sweep_q <= blank_last ? '0 : sweep_q + 1'b1;
				end
				OP_CLEAR: begin
					sweep_q   <= cells_last ? '0 : sweep_q + 1'b1;
					cur_col_q <= '0;
					cur_row_q <= '0;
					top_q     <= '0;
				end
				OP_SETCUR: begin
					cur_col_q <= rq_col_q;
					cur_row_q <= rq_row_q;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.load_rsp) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_rsp) begin
			rsp_q.cell_value <= (rq_type_q == REQ_READ) ? rdata_q : '0;
			rsp_q.cursor_col <= 7'(cur_col_q);
			rsp_q.cursor_row <= 5'(cur_row_q);
			rsp_q.scrolled   <= scrolled_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== hw/rtl/tcce_ctrl.sv =====
// tcce_ctrl: request sequencer of the text console cursor engine
// issues one datapath op per cycle, owns the request handshake
// depends on tcce_pkg
module tcce_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  tcce_pkg::stat_t stat,
	output tcce_pkg::cmd_t  cmd
);
	import tcce_pkg::*;

	typedef enum logic [6:0] {
		S_INIT  = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_EXEC  = 7'b0000100,
		S_STEP  = 7'b0001000,
		S_BLANK = 7'b0010000,
		S_CLEAR = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d      = state_q;
		cmd.op       = OP_NONE;
		cmd.load_rsp = 1'b0;
		req_ready    = 1'b0;
		case (state_q)
			S_INIT: begin
				// fill the store with the reset cell
				cmd.op = OP_FILL;
				if (stat.cells_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.op  = OP_ACCEPT;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				case (stat.req_type)
					REQ_PUT: begin
						state_d = stat.is_zero ? S_DONE : S_STEP;
					end
					REQ_READ: begin
						cmd.op  = OP_READ;
						state_d = S_DONE;
					end
					REQ_CLEAR: begin
						state_d = S_CLEAR;
					end
					REQ_SETCUR: begin
						cmd.op  = OP_SETCUR;
						state_d = S_DONE;
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_STEP: begin
				cmd.op = OP_STEP;
				if (stat.scroll) begin
					state_d = S_BLANK;
				end else if (stat.tab_more) begin
					state_d = S_STEP;
				end else begin
					state_d = S_DONE;
				end
			end
			S_BLANK: begin
				cmd.op = OP_BLANK;
				if (stat.blank_last) begin
					state_d = stat.tab_left ? S_STEP : S_DONE;
				end
			end
			S_CLEAR: begin
				cmd.op = OP_CLEAR;
				if (stat.cells_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				// once the response register is free, hand over the result and take the next item in the same cycle
				if (stat.rsp_free) begin
					cmd.load_rsp = 1'b1;
					req_ready    = 1'b1;
					if (req_valid) begin
						cmd.op  = OP_ACCEPT;
						state_d = S_EXEC;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hw/rtl/text_console_cursor_engine.sv =====
// text_console_cursor_engine: character cell console store with cursor, wrap and scroll
// a put writes one cell (a newline none), a tab TAB_SPACES spaces, a zero byte nothing; a clear
// sweeps every cell of the store, and each scroll blanks the new last row before the result
// throughput: the next item is taken in the cycle its predecessor's result is registered
// reset: a fill pass writes blank cells to the whole store before the first item
// depends on tcce_pkg, tcce_ctrl, tcce_datapath
module text_console_cursor_engine #(
	parameter int unsigned COLUMNS    = 80,
	parameter int unsigned ROWS       = 25,
	parameter int unsigned TAB_SPACES = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tcce_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [3:0]                     cfg_wdata,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  tcce_pkg::req_t                 req,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output tcce_pkg::rsp_t                 rsp
);
	import tcce_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	tcce_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	tcce_datapath #(
		.COLUMNS    (COLUMNS),
		.ROWS       (ROWS),
		.TAB_SPACES (TAB_SPACES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// one item at a time: no second accept right after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("item accepted while the previous one is in flight");

	a_cursor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ({1'b0, rsp.cursor_col} < 8'(COLUMNS)))
		else $error("cursor column left the screen");

	// a scroll always leaves the cursor on the last row
	a_scroll_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.scrolled |-> (rsp.cursor_row == 5'(ROWS - 1)))
		else $error("scroll without cursor on the last row");

endmodule
